### rtl/mmbd_pkg.sv
// mmbd_pkg: shared constants, access codes and structs of the memory bus decoder
// no dependencies; imported by every module of the block

package mmbd_pkg;

    // address map
    localparam logic [31:0] DATA_BASE  = 32'h2000_0000;
    localparam logic [31:0] INSTR_BASE = 32'h1000_0000;
    localparam logic [31:0] GETC_BASE  = 32'h3000_0000;
    localparam logic [31:0] PUTC_BASE  = 32'h3000_0004;

    // ram sizes in bytes and derived widths
    localparam int unsigned DATA_BYTES  = 65536;
    localparam int unsigned INSTR_BYTES = 65536;
    localparam int DATA_AW  = $clog2(DATA_BYTES);
    localparam int INSTR_AW = $clog2(INSTR_BYTES);
    localparam int DATA_IW  = DATA_AW - 2;
    localparam int INSTR_IW = INSTR_AW - 2;
    localparam int DATA_WORDS  = DATA_BYTES / 4;
    localparam int INSTR_WORDS = INSTR_BYTES / 4;
    localparam int ICNT_W = INSTR_AW + 1;

    // access codes
    localparam logic [2:0] FN_RD_WORD = 3'd0;
    localparam logic [2:0] FN_RD_HALF = 3'd1;
    localparam logic [2:0] FN_RD_BYTE = 3'd2;
    localparam logic [2:0] FN_WR_WORD = 3'd3;
    localparam logic [2:0] FN_WR_HALF = 3'd4;
    localparam logic [2:0] FN_WR_BYTE = 3'd5;
    localparam logic [2:0] FN_LOAD    = 3'd6;
    localparam logic [2:0] FN_FETCH   = 3'd7;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_RANGE    = 3'd1;
    localparam logic [2:0] ST_PROG_BIG = 3'd2;
    localparam logic [2:0] ST_PC_ALIGN = 3'd3;
    localparam logic [2:0] ST_PC_RANGE = 3'd4;

    // access size
    localparam logic [1:0] SZ_WORD = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_BYTE = 2'd2;

    // where the read data of a word comes from
    localparam logic [1:0] SRC_CONST = 2'd0;
    localparam logic [1:0] SRC_DATA  = 2'd1;
    localparam logic [1:0] SRC_INSTR = 2'd2;

    // memory side of one decoded access
    typedef struct packed {
        logic                d_rd;
        logic                d_wr;
        logic [3:0]          d_be;
        logic [DATA_IW-1:0]  d_idx;
        logic [31:0]         wdata;
        logic                i_rd;
        logic                i_load;
        logic [INSTR_IW-1:0] i_idx;
    } mmbd_mem_req_t;

    // result side of one decoded access
    typedef struct packed {
        logic [1:0]  src;
        logic [1:0]  size;
        logic [1:0]  off;
        logic [31:0] rdata;
        logic [2:0]  status;
        logic        taken;
        logic        ovalid;
        logic [7:0]  ochar;
    } mmbd_res_t;

endpackage

### rtl/mmbd_if.sv
// mmbd_req_if / mmbd_rsp_if: valid/ready channels of the memory bus decoder
// no dependencies

interface mmbd_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [7:0]  in_char;
    logic        in_eof;

    modport source (output valid, func, address, write_data, in_char, in_eof, input ready);
    modport sink   (input valid, func, address, write_data, in_char, in_eof, output ready);
endinterface

interface mmbd_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [2:0]  status;
    logic        char_taken;
    logic        out_valid;
    logic [7:0]  out_char;

    modport source (output valid, read_data, status, char_taken, out_valid, out_char,
                    input ready);
    modport sink   (input valid, read_data, status, char_taken, out_valid, out_char,
                    output ready);
endinterface

### rtl/mmbd_decode.sv
// mmbd_decode: address decode, alignment and range checks of one access
// depends on mmbd_pkg

module mmbd_decode (
    input  logic [2:0]                   func,
    input  logic [31:0]                  address,
    input  logic [31:0]                  write_data,
    input  logic [7:0]                   in_char,
    input  logic                         in_eof,
    input  logic [mmbd_pkg::ICNT_W-1:0]  icount,
    output mmbd_pkg::mmbd_res_t          res,
    output mmbd_pkg::mmbd_mem_req_t      mreq
);
    import mmbd_pkg::*;

    logic [1:0]  size;
    logic [1:0]  off;
    logic [1:0]  lane;
    logic        aligned;
    logic        getc_hit;
    logic        putc_hit;
    logic [32:0] d_diff;
    logic [32:0] i_diff;
    logic        d_in;
    logic        i_ge;
    logic        i_in;
    logic        i_loaded;
    logic        room;

    assign off      = address[1:0];
    assign getc_hit = address[31:2] == GETC_BASE[31:2];
    assign putc_hit = address[31:2] == PUTC_BASE[31:2];
    assign d_diff   = {1'b0, address} - {1'b0, DATA_BASE};
    assign i_diff   = {1'b0, address} - {1'b0, INSTR_BASE};
    assign d_in     = !d_diff[32] && (d_diff[31:0] < 32'(DATA_BYTES));
    assign i_ge     = !i_diff[32];
    assign i_in     = i_ge && (i_diff[31:0] < 32'(INSTR_BYTES));
    assign i_loaded = i_diff[31:0] < {{(32-ICNT_W){1'b0}}, icount};
    assign room     = {{(32-ICNT_W){1'b0}}, icount} < 32'(INSTR_BYTES);

    always_comb
    begin
        unique case (func) inside
            FN_RD_WORD, FN_WR_WORD, FN_LOAD, FN_FETCH:
            begin
                size = SZ_WORD;
                lane = 2'd0;
            end
            FN_RD_HALF, FN_WR_HALF:
            begin
                size = SZ_HALF;
                lane = 2'd2;
            end
            default:
            begin
                size = SZ_BYTE;
                lane = 2'd3;
            end
        endcase
        aligned = (size == SZ_WORD) ? (off == 2'd0) :
                  (size == SZ_HALF) ? !off[0] : 1'b1;
    end

    always_comb
    begin
        res        = '0;
        res.src    = SRC_CONST;
        res.size   = size;
        res.off    = off;
        res.status = ST_OK;
        mreq       = '0;
        mreq.d_idx = d_diff[DATA_AW-1:2];
        mreq.i_idx = i_diff[INSTR_AW-1:2];
        mreq.wdata = write_data;

        unique case (func) inside
            FN_RD_WORD, FN_RD_HALF, FN_RD_BYTE:
            begin
                if (getc_hit && off == lane)
                begin
                    if (in_eof)
                        res.rdata = 32'hFFFF_FFFF;
                    else
                    begin
                        res.rdata = {24'd0, in_char};
                        res.taken = 1'b1;
                    end
                end
                else if (getc_hit && off < lane && (size == SZ_BYTE || off == 2'd0))
                begin
                    // dead lane: consumes, reads zero; eof gives ones
                    if (in_eof)
                        res.rdata = (size == SZ_HALF) ? 32'h0000_FFFF : 32'h0000_00FF;
                    else
                        res.taken = 1'b1;
                end
                else if (aligned && d_in)
                begin
                    res.src   = SRC_DATA;
                    mreq.d_rd = 1'b1;
                end
                else if (aligned && i_in)
                begin
                    if (i_loaded)
                    begin
                        res.src   = SRC_INSTR;
                        mreq.i_rd = 1'b1;
                    end
                end
                else
                    res.status = ST_RANGE;
            end
            FN_WR_WORD, FN_WR_HALF, FN_WR_BYTE:
            begin
                if (putc_hit && off == lane)
                begin
                    res.ovalid = 1'b1;
                    res.ochar  = write_data[7:0];
                end
                else if (putc_hit && off < lane && (size == SZ_BYTE || off == 2'd0))
                    res.ovalid = 1'b1;
                else if (aligned && d_in)
                begin
                    mreq.d_wr = 1'b1;
                    case (size)
                        SZ_WORD:
                        begin
                            mreq.d_be  = 4'b1111;
                            mreq.wdata = write_data;
                        end
                        SZ_HALF:
                        begin
                            mreq.d_be  = off[1] ? 4'b0011 : 4'b1100;
                            mreq.wdata = {2{write_data[15:0]}};
                        end
                        default:
                        begin
                            mreq.wdata = {4{write_data[7:0]}};
                            case (off)
                                2'd0:    mreq.d_be = 4'b1000;
                                2'd1:    mreq.d_be = 4'b0100;
                                2'd2:    mreq.d_be = 4'b0010;
                                default: mreq.d_be = 4'b0001;
                            endcase
                        end
                    endcase
                end
                else
                    res.status = ST_RANGE;
            end
            FN_LOAD:
            begin
                if (room)
                    mreq.i_load = 1'b1;
                else
                    res.status = ST_PROG_BIG;
            end
            default:
            begin
                // instruction fetch
                if (off == 2'd0 && i_ge)
                begin
                    if (i_loaded)
                    begin
                        res.src   = SRC_INSTR;
                        mreq.i_rd = 1'b1;
                    end
                    else if (!i_in)
                        res.status = ST_PC_RANGE;
                end
                else
                    res.status = ST_PC_ALIGN;
            end
        endcase
    end

endmodule

### rtl/mmbd_data_mem.sv
// mmbd_data_mem: big-endian data ram, one word per entry, byte-lane writes
// depends on mmbd_pkg; cleared by a sweep after reset

module mmbd_data_mem (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mmbd_pkg::mmbd_mem_req_t  mreq,
    output logic                     busy,
    output logic [31:0]              rd_data
);
    import mmbd_pkg::*;

    logic [31:0]        mem [DATA_WORDS];
    logic [31:0]        rd_data_reg;
    logic [DATA_IW-1:0] clr_idx_reg;
    logic [DATA_IW-1:0] clr_idx_next;
    logic               busy_reg;
    logic               busy_next;

    always_comb
    begin
        clr_idx_next = clr_idx_reg;
        busy_next    = busy_reg;
        if (busy_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            busy_next    = !(&clr_idx_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else
        begin
            clr_idx_reg <= clr_idx_next;
            busy_reg    <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
            mem[clr_idx_reg] <= '0;
        else if (mreq.d_wr)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (mreq.d_be[i])
                    mem[mreq.d_idx][8*i +: 8] <= mreq.wdata[8*i +: 8];
            end
        end
        if (mreq.d_rd)
            rd_data_reg <= mem[mreq.d_idx];
    end

    assign busy    = busy_reg;
    assign rd_data = rd_data_reg;

    a_no_access_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !(mreq.d_wr || mreq.d_rd))
        else $error("data ram accessed during clearing sweep");

endmodule

### rtl/mmbd_instr_mem.sv
// mmbd_instr_mem: append-only instruction ram and its loaded byte count
// depends on mmbd_pkg

module mmbd_instr_mem (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mmbd_pkg::mmbd_mem_req_t      mreq,
    output logic [mmbd_pkg::ICNT_W-1:0]  icount,
    output logic [31:0]                  rd_data
);
    import mmbd_pkg::*;

    logic [31:0]       mem [INSTR_WORDS];
    logic [31:0]       rd_data_reg;
    logic [ICNT_W-1:0] cnt_reg;
    logic [ICNT_W-1:0] cnt_next;

    assign cnt_next = mreq.i_load ? cnt_reg + ICNT_W'(4) : cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (mreq.i_load)
            mem[cnt_reg[INSTR_AW-1:2]] <= mreq.wdata;
        if (mreq.i_rd)
            rd_data_reg <= mem[mreq.i_idx];
    end

    assign icount  = cnt_reg;
    assign rd_data = rd_data_reg;

    a_count_word_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[1:0] == 2'd0)
        else $error("instruction count not word aligned");

    a_load_adds_word: assert property (@(posedge clk) disable iff (!rst_n)
        mreq.i_load |=> cnt_reg == $past(cnt_reg) + ICNT_W'(4))
        else $error("instruction load did not advance count by one word");

endmodule

### rtl/mips_memory_bus_decoder_core.sv
// mips_memory_bus_decoder_core: top level of the memory bus decoder
// depends on mmbd_pkg, mmbd_if, mmbd_decode, mmbd_data_mem, mmbd_instr_mem

// usage
//   req carries one access per word: func, address, write_data and the
//   current input character state (in_char, in_eof). rsp returns exactly one
//   result word per access, in order: read_data, status, char_taken and the
//   character output (out_valid, out_char).
// pipeline and throughput
//   an access is decoded and issued to the ram at the edge it is accepted;
//   the ram read data is ready in the following cycle and the result then
//   enters the output register when that register is free, which raises
//   rsp.valid. one access per cycle is sustained while rsp.ready stays high;
//   the synchronous read of each ram port sets the two-stage depth.
// reset
//   control state clears at once; the data ram is then swept to zero, all
//   16384 words, one word per cycle, with req.ready low for the whole sweep.
//   the instruction ram is not cleared; the loaded count gates its reads.
// stalls
//   when rsp.ready is low the output register holds its word, the access in
//   the ram stage waits behind it, and req.ready drops once both are full.

module mips_memory_bus_decoder_core (
    input  logic       clk,
    input  logic       rst_n,
    mmbd_req_if.sink   req,
    mmbd_rsp_if.source rsp
);
    import mmbd_pkg::*;

    // result word extraction from a big-endian ram word
    function automatic logic [31:0] pick(input logic [31:0] word, input logic [1:0] size,
                                          input logic [1:0] off);
        logic [31:0] v;
        case (size)
            SZ_WORD: v = word;
            SZ_HALF: v = off[1] ? {16'd0, word[15:0]} : {16'd0, word[31:16]};
            default:
            begin
                case (off)
                    2'd0:    v = {24'd0, word[31:24]};
                    2'd1:    v = {24'd0, word[23:16]};
                    2'd2:    v = {24'd0, word[15:8]};
                    default: v = {24'd0, word[7:0]};
                endcase
            end
        endcase
        return v;
    endfunction

    mmbd_res_t         dec_res;
    mmbd_mem_req_t     dec_mreq;
    mmbd_mem_req_t     mreq;
    logic [ICNT_W-1:0] icount;
    logic              clr_busy;
    logic [31:0]       d_rd_data;
    logic [31:0]       i_rd_data;

    // ram stage: decoded access waiting for its read data
    mmbd_res_t   s1_res_reg;
    logic        s1_vld_reg;
    logic        s1_vld_next;

    // output register
    logic        out_vld_reg;
    logic        out_vld_next;
    logic [31:0] out_rdata_reg;
    logic [2:0]  out_status_reg;
    logic        out_taken_reg;
    logic        out_ovalid_reg;
    logic [7:0]  out_ochar_reg;
    logic [31:0] s1_rdata;

    logic out_free;
    logic s1_adv;
    logic fire;

    // handshake control
    assign out_free  = !out_vld_reg || rsp.ready;
    assign s1_adv    = s1_vld_reg && out_free;
    assign req.ready = !clr_busy && (!s1_vld_reg || out_free);
    assign fire      = req.valid && req.ready;

    mmbd_decode u_decode (
        .func       (req.func),
        .address    (req.address),
        .write_data (req.write_data),
        .in_char    (req.in_char),
        .in_eof     (req.in_eof),
        .icount     (icount),
        .res        (dec_res),
        .mreq       (dec_mreq)
    );

    // ram accesses only for an accepted word
    always_comb
    begin
        mreq        = dec_mreq;
        mreq.d_rd   = dec_mreq.d_rd && fire;
        mreq.d_wr   = dec_mreq.d_wr && fire;
        mreq.i_rd   = dec_mreq.i_rd && fire;
        mreq.i_load = dec_mreq.i_load && fire;
    end

    mmbd_data_mem u_data_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .mreq    (mreq),
        .busy    (clr_busy),
        .rd_data (d_rd_data)
    );

    mmbd_instr_mem u_instr_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .mreq    (mreq),
        .icount  (icount),
        .rd_data (i_rd_data)
    );

    // pick read data by source
    always_comb
    begin
        case (s1_res_reg.src)
            SRC_DATA:  s1_rdata = pick(d_rd_data, s1_res_reg.size, s1_res_reg.off);
            SRC_INSTR: s1_rdata = pick(i_rd_data, s1_res_reg.size, s1_res_reg.off);
            default:   s1_rdata = s1_res_reg.rdata;
        endcase
    end

    always_comb
    begin
        s1_vld_next = s1_vld_reg;
        if (fire)
            s1_vld_next = 1'b1;
        else if (s1_adv)
            s1_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        if (s1_adv)
            out_vld_next = 1'b1;
        else if (rsp.ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (fire)
            s1_res_reg <= dec_res;
        if (s1_adv)
        begin
            out_rdata_reg  <= s1_rdata;
            out_status_reg <= s1_res_reg.status;
            out_taken_reg  <= s1_res_reg.taken;
            out_ovalid_reg <= s1_res_reg.ovalid;
            out_ochar_reg  <= s1_res_reg.ochar;
        end
    end

    assign rsp.valid      = out_vld_reg;
    assign rsp.read_data  = out_rdata_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.char_taken = out_taken_reg;
    assign rsp.out_valid  = out_ovalid_reg;
    assign rsp.out_char   = out_ochar_reg;

    a_error_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_OK |-> rsp.read_data == 32'd0)
        else $error("failed access returned nonzero read data");

    a_char_zero_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.out_valid |-> rsp.out_char == 8'd0)
        else $error("character output nonzero without emit");

    a_take_or_emit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.char_taken && rsp.out_valid))
        else $error("one access both consumed and emitted a character");

endmodule
